[hdl/acs_pkg.sv]
package acs_pkg;

    localparam int DEFAULT_STORE_DEPTH = 1024;
    localparam int DEFAULT_WORD_BITS   = 32;

    localparam int DRAW_BITS  = 32;
    localparam int CNT_BITS   = $clog2(DRAW_BITS + 1);
    localparam int DATA_BITS  = 32;
    localparam int INDEX_BITS = 10;

    localparam logic [DRAW_BITS-1:0] SEED_RESET = DRAW_BITS'(1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [DRAW_BITS-1:0] xorshift_next(input logic [DRAW_BITS-1:0] x);
        logic [DRAW_BITS-1:0] a;
        logic [DRAW_BITS-1:0] b;
        logic [DRAW_BITS-1:0] c;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        c = b ^ (b << 5);
        return c;
    endfunction

endpackage

[hdl/array_cyclic_shuffle_core.sv]
// Load request: ready again the cycle after acceptance, unless it starts the shuffle.
// Read request: result is loaded into the output register once that frees; ready again then.
// Last load starts the shuffle when the count is at least 2: per swap one draw, the serial modulo
// unit and a swap in memory (RDA, RDB, WRA, WRB); (count - 1) swaps, not ready meanwhile.
// Reset: synchronous, active low; clears count, state and output valid, loads generator with 1.
// Store contents are not cleared by reset.
module array_cyclic_shuffle_core #(
    parameter int STORE_DEPTH = acs_pkg::DEFAULT_STORE_DEPTH,
    parameter int WORD_BITS   = acs_pkg::DEFAULT_WORD_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_operation,
    input  logic [acs_pkg::DATA_BITS-1:0]     i_data_word,
    input  logic                              i_is_last,
    input  logic [acs_pkg::INDEX_BITS-1:0]    i_read_index,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [acs_pkg::DATA_BITS-1:0]     o_read_word,
    output logic                              o_out_of_range,
    input  logic                              i_cfg_write_en,
    input  logic [acs_pkg::DRAW_BITS-1:0]     i_cfg_write_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDOUT = 3'd1;
    localparam logic [2:0] S_DRAW  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_RDA   = 3'd4;
    localparam logic [2:0] S_RDB   = 3'd5;
    localparam logic [2:0] S_WRA   = 3'd6;
    localparam logic [2:0] S_WRB   = 3'd7;

    logic [WORD_BITS-1:0]          mem [STORE_DEPTH];

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_blk_done;
    logic                          n_blk_done;
    logic [acs_pkg::DRAW_BITS-1:0] r_gen;
    logic [acs_pkg::DRAW_BITS-1:0] n_gen;
    logic [AW-1:0]                 r_pos;
    logic [AW-1:0]                 n_pos;
    logic [AW-1:0]                 r_rd_addr;
    logic [AW-1:0]                 n_rd_addr;
    logic                          r_oor_pend;
    logic                          n_oor_pend;
    logic [WORD_BITS-1:0]          r_held;
    logic [WORD_BITS-1:0]          n_held;
    logic [WORD_BITS-1:0]          r_rd_data;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [acs_pkg::DATA_BITS-1:0] r_out_word;
    logic [acs_pkg::DATA_BITS-1:0] n_out_word;
    logic                          r_out_oor;
    logic                          n_out_oor;

    logic                          in_acc;
    logic                          out_acc;
    logic [CW-1:0]                 base;
    logic                          has_room;
    logic [CW-1:0]                 new_count;
    logic                          idx_ok;
    logic [31:0]                   idx_ext;
    logic [63:0]                   wr_ext;
    logic [63:0]                   rd_ext;
    logic [acs_pkg::DRAW_BITS-1:0] draw;

    logic                          mem_we;
    logic [AW-1:0]                 mem_wa;
    logic [WORD_BITS-1:0]          mem_wd;
    logic [AW-1:0]                 mem_ra;

    logic                          div_start;
    acs_pkg::t_div_stat            div_stat;
    logic [AW-1:0]                 div_rem;

    acs_mod_unit #(
        .DIV_BITS (AW)
    ) u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (draw),
        .i_divisor   (r_pos),
        .o_stat      (div_stat),
        .o_remainder (div_rem)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_acc    = r_out_valid & i_out_ready;

    assign base      = r_blk_done ? '0 : r_count;
    assign has_room  = base < CW'(STORE_DEPTH);
    assign new_count = has_room ? base + CW'(1) : base;
    assign idx_ext   = 32'(i_read_index);
    assign idx_ok    = idx_ext < 32'(r_count);
    assign wr_ext    = {32'd0, i_data_word};
    assign rd_ext    = 64'(r_rd_data);
    assign draw      = acs_pkg::xorshift_next(r_gen);
    assign div_start = (r_state == S_DRAW) && !div_stat.busy;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = base[AW-1:0];
        mem_wd = wr_ext[WORD_BITS-1:0];
        mem_ra = idx_ext[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                mem_we = in_acc && (i_operation == acs_pkg::OP_LOAD) && has_room;
            end
            S_RDOUT: begin
                mem_ra = r_rd_addr;
            end
            S_RDA: begin
                mem_ra = r_pos;
            end
            S_RDB: begin
                mem_ra = div_rem;
            end
            S_WRA: begin
                mem_we = 1'b1;
                mem_wa = r_pos;
                mem_wd = r_rd_data;
            end
            S_WRB: begin
                mem_we = 1'b1;
                mem_wa = div_rem;
                mem_wd = r_held;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_blk_done  = r_blk_done;
        n_gen       = r_gen;
        n_pos       = r_pos;
        n_rd_addr   = r_rd_addr;
        n_oor_pend  = r_oor_pend;
        n_held      = r_held;
        n_out_valid = r_out_valid && !out_acc;
        n_out_word  = r_out_word;
        n_out_oor   = r_out_oor;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == acs_pkg::OP_LOAD) begin
                        n_count    = new_count;
                        n_blk_done = 1'b0;
                        if (i_is_last) begin
                            n_blk_done = 1'b1;
                            if (new_count >= CW'(2)) begin
                                n_pos   = AW'(new_count - CW'(1));
                                n_state = S_DRAW;
                            end
                        end
                    end else begin
                        n_rd_addr  = idx_ext[AW-1:0];
                        n_oor_pend = !idx_ok;
                        n_state    = S_RDOUT;
                    end
                end
            end
            S_RDOUT: begin
                if (!r_out_valid || out_acc) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_oor_pend ? '0 : rd_ext[acs_pkg::DATA_BITS-1:0];
                    n_out_oor   = r_oor_pend;
                    n_state     = S_IDLE;
                end
            end
            S_DRAW: begin
                n_gen   = draw;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                n_state = S_RDB;
            end
            S_RDB: begin
                n_held  = r_rd_data;
                n_state = S_WRA;
            end
            S_WRA: begin
                n_state = S_WRB;
            end
            S_WRB: begin
                if (r_pos == AW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_pos   = r_pos - AW'(1);
                    n_state = S_DRAW;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_write_en) begin
            n_gen = i_cfg_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_rd_addr  <= n_rd_addr;
        r_oor_pend <= n_oor_pend;
        r_held     <= n_held;
        r_out_word <= n_out_word;
        r_out_oor  <= n_out_oor;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_blk_done  <= 1'b0;
            r_gen       <= acs_pkg::SEED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_blk_done  <= n_blk_done;
            r_gen       <= n_gen;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_word    = r_out_word;
    assign o_out_of_range = r_out_oor;

endmodule

[hdl/acs_mod_unit.sv]
module acs_mod_unit #(
    parameter int DIV_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [acs_pkg::DRAW_BITS-1:0]      i_dividend,
    input  logic [DIV_BITS-1:0]                i_divisor,
    output acs_pkg::t_div_stat                 o_stat,
    output logic [DIV_BITS-1:0]                o_remainder
);

    logic [acs_pkg::DRAW_BITS-1:0] r_quot;
    logic [acs_pkg::DRAW_BITS-1:0] n_quot;
    logic [DIV_BITS-1:0]           r_rem;
    logic [DIV_BITS-1:0]           n_rem;
    logic [acs_pkg::CNT_BITS-1:0]  r_cnt;
    logic [acs_pkg::CNT_BITS-1:0]  n_cnt;
    logic                          r_busy;
    logic                          n_busy;
    logic                          r_done;
    logic                          n_done;
    logic [DIV_BITS:0]             trial;
    logic [DIV_BITS:0]             diff;

    assign trial = {r_rem, r_quot[acs_pkg::DRAW_BITS-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = acs_pkg::CNT_BITS'(acs_pkg::DRAW_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[acs_pkg::DRAW_BITS-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = diff[DIV_BITS-1:0];
            end else begin
                n_rem = trial[DIV_BITS-1:0];
            end
            n_cnt = r_cnt - acs_pkg::CNT_BITS'(1);
            if (r_cnt == acs_pkg::CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_remainder = r_rem;

endmodule

[hdl/acs_checker.sv]
module acs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              i_operation,
    input logic                              i_is_last,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [acs_pkg::DATA_BITS-1:0]     o_read_word,
    input logic                              o_out_of_range
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_read_word) && $stable(o_out_of_range))
        else $error("stalled result changed or dropped");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_read_word == '0)
        else $error("out-of-range result carries nonzero word");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == acs_pkg::OP_LOAD) && !i_is_last
            |=> o_in_ready)
        else $error("plain load request did not complete in one cycle");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == acs_pkg::OP_READ) |=> !o_in_ready)
        else $error("read request did not hold off the next request");

endmodule

bind array_cyclic_shuffle_core acs_checker u_acs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_operation    (i_operation),
    .i_is_last      (i_is_last),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_read_word    (o_read_word),
    .o_out_of_range (o_out_of_range)
);
